FILE: rtl/lru_frame_reclaimer_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the frame reclaimer
// ----------------------------------------------------------------------------
`ifndef LRU_FRAME_RECLAIMER_TOP_ASSERT_SVH
`define LRU_FRAME_RECLAIMER_TOP_ASSERT_SVH

// same-cycle implication
`define LFR_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LFR_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/lfr_pkg.sv
// ----------------------------------------------------------------------------
// lfr_pkg
// Shared types and constants of the frame reclaimer.
// ----------------------------------------------------------------------------
package lfr_pkg;

  localparam logic [1:0] OP_PLACE   = 2'd0;
  localparam logic [1:0] OP_FREE    = 2'd1;
  localparam logic [1:0] OP_RECLAIM = 2'd2;

  localparam int         MAX_RESULTS = 16;
  localparam logic [4:0] LIMIT_RESET = 5'd12;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_LAST  = 4'b0100,
    ST_EVICT = 4'b1000
  } lfr_state_t;

  // frame store port control
  typedef struct packed {
    logic we;
    logic re;
  } store_ctl_t;

endpackage

FILE: rtl/lfr_frame_store.sv
// ----------------------------------------------------------------------------
// lfr_frame_store
// Page and timestamp memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module lfr_frame_store
  import lfr_pkg::*;
#(
  parameter int FRAME_COUNT = 16,
  parameter int TIME_BITS   = 32,
  parameter int PAGE_BITS   = 16,
  localparam int IDX_W      = $clog2(FRAME_COUNT)
) (
  input  logic                 clk,
  input  store_ctl_t           ctl,
  input  logic [IDX_W-1:0]     wr_addr,
  input  logic [PAGE_BITS-1:0] wr_page,
  input  logic [TIME_BITS-1:0] wr_time,
  input  logic [IDX_W-1:0]     rd_addr,
  output logic [PAGE_BITS-1:0] rd_page,
  output logic [TIME_BITS-1:0] rd_time
);

  logic [PAGE_BITS-1:0] page_mem [FRAME_COUNT];
  logic [TIME_BITS-1:0] time_mem [FRAME_COUNT];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      page_mem[wr_addr] <= wr_page;
      time_mem[wr_addr] <= wr_time;
    end
    if (ctl.re) begin
      rd_page <= page_mem[rd_addr];
      rd_time <= time_mem[rd_addr];
    end
  end

endmodule

FILE: rtl/lru_frame_reclaimer_top.sv
// ----------------------------------------------------------------------------
// lru_frame_reclaimer_top
// Place, free and opcode 3 leave busy low, so the next item can follow.
// Reclaim: each eviction is a scan of all frames through the one memory read port
// and one time comparator, followed by the LAST and EVICT states; up to 16 results.
// An empty reclaim gives its single result in the cycle after the item.
// Results are strobed for one cycle each and cannot be stalled.
// Synchronous reset empties the table and sets the limit to 12; no clearing pass.
// ----------------------------------------------------------------------------
`include "lru_frame_reclaimer_top_assert.svh"

module lru_frame_reclaimer_top
  import lfr_pkg::*;
#(
  parameter int FRAME_COUNT = 16,
  parameter int TIME_BITS   = 32,
  parameter int PAGE_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [3:0]  frame_index,
  input  logic [15:0] page_number,
  input  logic [31:0] ref_time,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  output logic        result_strobe,
  output logic        evicted_valid,
  output logic [15:0] evicted_page,
  output logic [3:0]  evicted_frame,
  output logic        last_of_run
);

  localparam int IDX_W = $clog2(FRAME_COUNT);
  localparam int CNT_W = $clog2(FRAME_COUNT + 1);
  localparam int RUN_W = $clog2(MAX_RESULTS + 1);

  lfr_state_t           state;
  logic [4:0]           occupancy_limit;
  logic [FRAME_COUNT-1:0] occ;
  logic [CNT_W-1:0]     occ_count;
  logic [IDX_W-1:0]     scan_idx;
  logic [RUN_W-1:0]     run_count;

  logic                 cmp_vld;
  logic                 cmp_occ;
  logic [IDX_W-1:0]     cmp_idx;
  logic                 best_found;
  logic [IDX_W-1:0]     best_idx;
  logic [TIME_BITS-1:0] best_time;
  logic [PAGE_BITS-1:0] best_page;

  store_ctl_t           store_ctl;
  logic [IDX_W-1:0]     wr_addr;
  logic [PAGE_BITS-1:0] rd_page;
  logic [TIME_BITS-1:0] rd_time;

  logic                 accept;
  logic                 in_range;
  logic                 can_evict;
  logic [CNT_W-1:0]     count_after;
  logic                 run_last;

  assign busy        = (state != ST_IDLE);
  assign accept      = start && !busy;
  assign wr_addr     = IDX_W'(frame_index);
  assign in_range    = (32'(frame_index) < FRAME_COUNT);
  assign can_evict   = (32'(occ_count) >= 32'(occupancy_limit)) && (occ_count != '0);
  assign count_after = occ_count - CNT_W'(1);
  assign run_last    = (run_count == RUN_W'(MAX_RESULTS - 1))
                    || (32'(count_after) < 32'(occupancy_limit))
                    || (count_after == '0);

  assign store_ctl.we = accept && (opcode == OP_PLACE) && in_range;
  assign store_ctl.re = (state == ST_SCAN);

  lfr_frame_store #(
    .FRAME_COUNT (FRAME_COUNT),
    .TIME_BITS   (TIME_BITS),
    .PAGE_BITS   (PAGE_BITS)
  ) u_store (
    .clk     (clk),
    .ctl     (store_ctl),
    .wr_addr (wr_addr),
    .wr_page (PAGE_BITS'(page_number)),
    .wr_time (TIME_BITS'(ref_time)),
    .rd_addr (scan_idx),
    .rd_page (rd_page),
    .rd_time (rd_time)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      occupancy_limit <= cfg_wdata;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      occ           <= '0;
      occ_count     <= '0;
      scan_idx      <= '0;
      run_count     <= '0;
      cmp_vld       <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      cmp_vld       <= (state == ST_SCAN);
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (opcode)
              OP_PLACE: begin
                if (in_range && !occ[wr_addr]) begin
                  occ[wr_addr] <= 1'b1;
                  occ_count    <= occ_count + CNT_W'(1);
                end
              end
              OP_FREE: begin
                if (in_range && occ[wr_addr]) begin
                  occ[wr_addr] <= 1'b0;
                  occ_count    <= occ_count - CNT_W'(1);
                end
              end
              OP_RECLAIM: begin
                if (can_evict) begin
                  state     <= ST_SCAN;
                  scan_idx  <= '0;
                  run_count <= '0;
                end else begin
                  result_strobe <= 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          scan_idx <= scan_idx + IDX_W'(1);
          if (scan_idx == IDX_W'(FRAME_COUNT - 1)) begin
            state <= ST_LAST;
          end
        end
        ST_LAST: begin
          state <= ST_EVICT;
        end
        ST_EVICT: begin
          occ[best_idx] <= 1'b0;
          occ_count     <= count_after;
          run_count     <= run_count + RUN_W'(1);
          result_strobe <= 1'b1;
          scan_idx      <= '0;
          state         <= run_last ? ST_IDLE : ST_SCAN;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // scan datapath: the memory read is registered, and the index and occupied mark are registered alongside it
  always_ff @(posedge clk) begin
    if (state == ST_SCAN) begin
      cmp_idx <= scan_idx;
      cmp_occ <= occ[scan_idx];
    end
    if (state == ST_EVICT || accept) begin
      best_found <= 1'b0;
    end else if (cmp_vld && cmp_occ && (!best_found || rd_time < best_time)) begin
      // strict less-than keeps the lowest index on equal times
      best_found <= 1'b1;
      best_idx   <= cmp_idx;
      best_time  <= rd_time;
      best_page  <= rd_page;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state == ST_EVICT) begin
      evicted_valid <= 1'b1;
      evicted_page  <= 16'(best_page);
      evicted_frame <= 4'(best_idx);
      last_of_run   <= run_last;
    end else if (accept && opcode == OP_RECLAIM) begin
      evicted_valid <= 1'b0;
      evicted_page  <= '0;
      evicted_frame <= '0;
      last_of_run   <= 1'b1;
    end
  end

  `LFR_ASSERT_IMP(a_count_matches, clk, rst, 1'b1, $countones(occ) == 32'(occ_count), "occupied count out of step with marks")
  `LFR_ASSERT_NXT(a_evict_strobes, clk, rst, state == ST_EVICT, result_strobe && evicted_valid, "eviction gave no valid result")
  `LFR_ASSERT_IMP(a_last_idles, clk, rst, result_strobe && last_of_run, state == ST_IDLE, "block still busy after last result")
  `LFR_ASSERT_IMP(a_mid_scans, clk, rst, result_strobe && !last_of_run, state == ST_SCAN && evicted_valid, "run continued without a new scan")

endmodule
